// ===== rtl/core/lmfce_pkg.sv =====
// ----------------------------------------------------------------------------
// lmfce_pkg
// Shared types and constants for the led matrix frame command engine:
// command codes, status codes, driver register addresses, queue entries.
// ----------------------------------------------------------------------------
package lmfce_pkg;

  typedef enum logic [3:0] {
    KindSetPixel  = 4'd0,
    KindGetPixel  = 4'd1,
    KindSetRow    = 4'd2,
    KindSetColumn = 4'd3,
    KindShiftLeft = 4'd4,
    KindShiftRight = 4'd5,
    KindClear     = 4'd6,
    KindRefresh   = 4'd7,
    KindIntensity = 4'd8,
    KindPowerUp   = 4'd9,
    KindPowerDown = 4'd10
  } cmd_kind_e;

  // result status codes
  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusRange      = 2'd1;
  localparam logic [1:0] StatusClamped    = 2'd2;
  localparam logic [1:0] StatusNotPowered = 2'd3;

  // driver register map
  localparam logic [3:0] AddrDigit0    = 4'h1;
  localparam logic [3:0] AddrDecode    = 4'h9;
  localparam logic [3:0] AddrIntensity = 4'hA;
  localparam logic [3:0] AddrScanLimit = 4'hB;
  localparam logic [3:0] AddrShutdown  = 4'hC;
  localparam logic [3:0] AddrDispTest  = 4'hF;

  localparam logic [7:0] IntensityMax  = 8'h0F;
  localparam logic [7:0] IntensityInit = IntensityMax / 8'd2;
  localparam logic [7:0] ShutdownOn    = 8'h00;
  localparam logic [7:0] ShutdownOff   = 8'h01;

  // power-up sequence: five setup writes, the rows, then wake-up
  localparam int unsigned PowerUpSetup = 5;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [3:0] row_index;
    logic [3:0] col_index;
    logic [7:0] value_byte;
    logic       pixel_on;
    logic       wrap_around;
    logic       range_err;
  } cmd_entry_t;

  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } q_port_t;

endpackage

// ===== rtl/core/lmfce_if.sv =====
// ----------------------------------------------------------------------------
// lmfce command and result channels
// Valid/ready channels carrying one display command and one driver result.
// ----------------------------------------------------------------------------
interface lmfce_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [3:0] row_index;
  logic [3:0] col_index;
  logic [7:0] value_byte;
  logic       pixel_on;
  logic       wrap_around;

  modport source (
    output valid, kind, row_index, col_index, value_byte, pixel_on, wrap_around,
    input  ready
  );
  modport sink (
    input  valid, kind, row_index, col_index, value_byte, pixel_on, wrap_around,
    output ready
  );
endinterface

interface lmfce_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_addr;
  logic [7:0] reg_data;
  logic       write_valid;
  logic       pixel_value;
  logic [1:0] status;
  logic       last;

  modport source (
    output valid, reg_addr, reg_data, write_valid, pixel_value, status, last,
    input  ready
  );
  modport sink (
    input  valid, reg_addr, reg_data, write_valid, pixel_value, status, last,
    output ready
  );
endinterface

// ===== rtl/core/lmfce_front.sv =====
// ----------------------------------------------------------------------------
// lmfce_front
// Accepts commands, drops unused codes and flags out-of-range coordinates
// before pushing the command into the queue.
// ----------------------------------------------------------------------------
module lmfce_front #(
  parameter int unsigned MATRIX_DIM = 8
) (
  lmfce_cmd_if.sink          cmd_i,
  input  logic               q_full_i,
  output lmfce_pkg::q_port_t q_wr_o
);
  import lmfce_pkg::*;

  localparam logic [3:0] DimLimit = 4'(MATRIX_DIM);

  logic row_bad;
  logic col_bad;
  logic known;
  logic range_err;

  assign cmd_i.ready = !q_full_i;

  assign row_bad = cmd_i.row_index >= DimLimit;
  assign col_bad = cmd_i.col_index >= DimLimit;
  assign known   = cmd_i.kind <= 4'(KindPowerDown);

  always_comb begin
    unique case (cmd_i.kind)
      4'(KindSetPixel), 4'(KindGetPixel): range_err = row_bad || col_bad;
      4'(KindSetRow):                     range_err = row_bad;
      4'(KindSetColumn):                  range_err = col_bad;
      default:                            range_err = 1'b0;
    endcase
  end

  // unused codes are taken and dropped without a result
  assign q_wr_o.valid             = cmd_i.valid && !q_full_i && known;
  assign q_wr_o.entry.kind        = cmd_kind_e'(cmd_i.kind);
  assign q_wr_o.entry.row_index   = cmd_i.row_index;
  assign q_wr_o.entry.col_index   = cmd_i.col_index;
  assign q_wr_o.entry.value_byte  = cmd_i.value_byte;
  assign q_wr_o.entry.pixel_on    = cmd_i.pixel_on;
  assign q_wr_o.entry.wrap_around = cmd_i.wrap_around;
  assign q_wr_o.entry.range_err   = range_err;

endmodule

// ===== rtl/core/lmfce_queue.sv =====
// ----------------------------------------------------------------------------
// lmfce_queue
// Small command queue between the front and the back part.
// ----------------------------------------------------------------------------
module lmfce_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lmfce_pkg::q_port_t q_wr_i,
  output logic               q_full_o,
  output lmfce_pkg::q_port_t q_rd_o,
  input  logic               q_pop_i
);
  import lmfce_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cmd_entry_t      mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign q_full_o     = count_q == CntFull;
  assign q_rd_o.valid = count_q != '0;
  assign q_rd_o.entry = mem_q[rd_ptr_q];

  assign push = q_wr_i.valid && !q_full_o;
  assign pop  = q_pop_i && q_rd_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= q_wr_i.entry;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue fill count above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not drain the queue");

endmodule

// ===== rtl/core/lmfce_back.sv =====
// ----------------------------------------------------------------------------
// lmfce_back
// Executes queued commands: holds the frame and the powered flag and emits
// one driver result per cycle through an output register while a command
// runs and the result side is not stalling.
module lmfce_back #(
  parameter int unsigned MATRIX_DIM = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lmfce_pkg::q_port_t q_rd_i,
  output logic               q_pop_o,
  lmfce_res_if.source        res_o
);
  import lmfce_pkg::*;

  localparam int unsigned RowW     = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
  localparam int unsigned MaxSteps = PowerUpSetup + MATRIX_DIM + 1;
  localparam int unsigned CntW     = $clog2(MaxSteps);
  localparam logic [CntW-1:0] RowsLast  = CntW'(MATRIX_DIM - 1);
  localparam logic [CntW-1:0] PuLast    = CntW'(MaxSteps - 1);
  localparam logic [CntW-1:0] PuRowBase = CntW'(PowerUpSetup);
  localparam logic [CntW-1:0] PuRowEnd  = CntW'(PowerUpSetup + MATRIX_DIM);
  localparam logic [7:0]      ScanLimit = 8'(MATRIX_DIM - 1);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic            state_q, state_d;
  cmd_entry_t      cmd_q;
  logic [CntW-1:0] cnt_q;
  logic            powered_q;
  logic [7:0]      frame_q [MATRIX_DIM];

  logic            res_valid_q;
  logic [3:0]      res_addr_q;
  logic [7:0]      res_data_q;
  logic            res_wv_q;
  logic            res_pix_q;
  logic [1:0]      res_status_q;
  logic            res_last_q;

  logic            adv;
  logic            not_pow;
  logic [CntW-1:0] last_idx;
  logic            step_last;
  logic [CntW-1:0] pu_row;
  logic            pu_row_step;
  logic [RowW-1:0] ri;
  logic [2:0]      ri3;
  logic [2:0]      col3;
  logic [7:0]      cur;
  logic [7:0]      mask;
  logic [7:0]      nv;

  logic [3:0]      s_addr;
  logic [7:0]      s_data;
  logic            s_wv;
  logic            s_pix;
  logic [1:0]      s_status;
  logic            s_fwe;

  assign not_pow = !powered_q && (cmd_q.kind != KindPowerUp);
  assign adv     = (state_q == StRun) && (!res_valid_q || res_o.ready);
  assign q_pop_o = (state_q == StIdle);

  always_comb begin
    if (not_pow || cmd_q.range_err) begin
      last_idx = '0;
    end else begin
      unique case (cmd_q.kind)
        KindSetColumn, KindShiftLeft, KindShiftRight, KindClear, KindRefresh:
          last_idx = RowsLast;
        KindPowerUp: last_idx = PuLast;
        default:     last_idx = '0;
      endcase
    end
  end
  assign step_last = cnt_q == last_idx;

  assign pu_row      = cnt_q - PuRowBase;
  assign pu_row_step = (cnt_q >= PuRowBase) && (cnt_q < PuRowEnd);

  // one frame row is read per step
  always_comb begin
    unique case (cmd_q.kind)
      KindSetPixel, KindGetPixel, KindSetRow: ri = cmd_q.row_index[RowW-1:0];
      KindPowerUp:                            ri = pu_row[RowW-1:0];
      default:                                ri = cnt_q[RowW-1:0];
    endcase
  end
  assign ri3  = 3'(ri);
  assign col3 = cmd_q.col_index[2:0];
  assign cur  = frame_q[ri];
  assign mask = 8'h01 << col3;

  always_comb begin
    case (cmd_q.kind)
      KindSetPixel:   nv = cmd_q.pixel_on ? (cur | mask) : (cur & ~mask);
      KindSetRow:     nv = cmd_q.value_byte;
      KindSetColumn:  nv = cmd_q.value_byte[ri3] ? (cur | mask) : (cur & ~mask);
      KindShiftLeft:  nv = {cur[6:0], cmd_q.wrap_around & cur[7]};
      KindShiftRight: nv = {cmd_q.wrap_around & cur[0], cur[7:1]};
      KindRefresh:    nv = cur;
      default:        nv = 8'h00;
    endcase
  end

  always_comb begin
    s_addr   = '0;
    s_data   = '0;
    s_wv     = 1'b0;
    s_pix    = 1'b0;
    s_status = StatusOk;
    s_fwe    = 1'b0;
    if (not_pow) begin
      s_status = StatusNotPowered;
    end else if (cmd_q.range_err) begin
      s_status = StatusRange;
    end else begin
      unique case (cmd_q.kind)
        KindGetPixel: begin
          s_pix = cur[col3];
        end
        KindSetPixel, KindSetRow, KindSetColumn, KindShiftLeft, KindShiftRight,
        KindClear, KindRefresh: begin
          s_addr = AddrDigit0 + 4'(ri3);
          s_data = nv;
          s_wv   = 1'b1;
          s_fwe  = 1'b1;
        end
        KindIntensity: begin
          s_addr = AddrIntensity;
          s_wv   = 1'b1;
          if (cmd_q.value_byte > IntensityMax) begin
            s_data   = IntensityMax;
            s_status = StatusClamped;
          end else begin
            s_data = cmd_q.value_byte;
          end
        end
        KindPowerUp: begin
          s_wv = 1'b1;
          if (pu_row_step) begin
            s_addr = AddrDigit0 + 4'(ri3);
            s_data = 8'h00;
            s_fwe  = 1'b1;
          end else if (cnt_q == CntW'(0)) begin
            s_addr = AddrShutdown;
            s_data = ShutdownOn;
          end else if (cnt_q == CntW'(1)) begin
            s_addr = AddrDispTest;
          end else if (cnt_q == CntW'(2)) begin
            s_addr = AddrDecode;
          end else if (cnt_q == CntW'(3)) begin
            s_addr = AddrScanLimit;
            s_data = ScanLimit;
          end else if (cnt_q == CntW'(4)) begin
            s_addr = AddrIntensity;
            s_data = IntensityInit;
          end else begin
            s_addr = AddrShutdown;
            s_data = ShutdownOff;
          end
        end
        KindPowerDown: begin
          s_addr = AddrShutdown;
          s_data = ShutdownOn;
          s_wv   = 1'b1;
        end
        default: begin
          s_wv = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (q_rd_i.valid) state_d = StRun;
      StRun:  if (adv && step_last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      powered_q   <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < int'(MATRIX_DIM); i++) begin
        frame_q[i] <= 8'h00;
      end
    end else begin
      state_q <= state_d;
      if (state_q == StIdle) begin
        cnt_q <= '0;
      end else if (adv) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (adv) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (adv && s_fwe) begin
        frame_q[ri] <= nv;
      end
      if (adv && step_last && !not_pow) begin
        if (cmd_q.kind == KindPowerUp) begin
          powered_q <= 1'b1;
        end else if (cmd_q.kind == KindPowerDown) begin
          powered_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_rd_i.valid) begin
      cmd_q <= q_rd_i.entry;
    end
    if (adv) begin
      res_addr_q   <= s_addr;
      res_data_q   <= s_data;
      res_wv_q     <= s_wv;
      res_pix_q    <= s_pix;
      res_status_q <= s_status;
      res_last_q   <= step_last;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.reg_addr    = res_addr_q;
  assign res_o.reg_data    = res_data_q;
  assign res_o.write_valid = res_wv_q;
  assign res_o.pixel_value = res_pix_q;
  assign res_o.status      = res_status_q;
  assign res_o.last        = res_last_q;

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_wv_q) |-> (res_addr_q == 4'h0 && res_data_q == 8'h00))
    else $error("result without write carries address or data");

  a_power_on_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(powered_q) |-> (res_valid_q && res_last_q && res_addr_q == AddrShutdown
                          && res_data_q == ShutdownOff))
    else $error("powered set without the wake-up write");

  a_unpowered_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_status_q == StatusNotPowered) |-> (!res_wv_q && res_last_q))
    else $error("write issued while not powered");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (cnt_q <= last_idx))
    else $error("step counter ran past the command's last result");

endmodule

// ===== rtl/core/led_matrix_frame_command_engine.sv =====
// ----------------------------------------------------------------------------
// led_matrix_frame_command_engine
// Turns display commands into driver register writes from an 8x8 frame.
// ----------------------------------------------------------------------------
// a taken command passes through the queue and the executor's command register
// before its first result is registered; the executor works on one command
//   at a time, loading it while idle and then stepping once per result
// a 4-entry command queue keeps accepting commands until full while results are drained
// reset: frame cleared, powered flag cleared, queue and output emptied
module led_matrix_frame_command_engine #(
  parameter int unsigned MATRIX_DIM = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmfce_cmd_if.sink   cmd_i,
  lmfce_res_if.source res_o
);
  import lmfce_pkg::*;

  q_port_t q_wr;
  q_port_t q_rd;
  logic    q_full;
  logic    q_pop;

  lmfce_front #(
    .MATRIX_DIM (MATRIX_DIM)
  ) u_front (
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  lmfce_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_wr_i   (q_wr),
    .q_full_o (q_full),
    .q_rd_o   (q_rd),
    .q_pop_i  (q_pop)
  );

  lmfce_back #(
    .MATRIX_DIM (MATRIX_DIM)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_rd_i  (q_rd),
    .q_pop_o (q_pop),
    .res_o   (res_o)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for led_matrix_frame_command_engine
// Drives display commands into the engine and checks each driver result
// against a local frame/power model or, for typed directed rows, against the
// result typed into the table. A short directed table comes first, then random
// phases with idle gaps, a long result back-pressure stretch and a full drain.
// ----------------------------------------------------------------------------
module testbench;
  import lmfce_pkg::*;

  localparam int Dim           = 8;
  localparam int SinkHoldCycles = 150;
  localparam int WatchdogLimit = 1000;
  localparam int EndPause      = 40;

  // command codes the engine ignores
  localparam logic [3:0] KindUnusedLow = 4'd11;
  localparam logic [3:0] KindUnusedTop = 4'd15;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] row_index;
    logic [3:0] col_index;
    logic [7:0] value_byte;
    logic       pixel_on;
    logic       wrap_around;
  } command_t;

  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
    logic       write_valid;
    logic       pixel_value;
    logic [1:0] status;
    logic       last;
  } drv_result_t;

  typedef struct packed {
    command_t    req;
    logic        typed;
    drv_result_t want;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lmfce_cmd_if cmd_if ();
  lmfce_res_if res_if ();

  led_matrix_frame_command_engine #(
    .MATRIX_DIM(Dim)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // frame model
  logic [7:0]  model_rows [Dim];
  logic        model_powered;
  drv_result_t fresh_results[$];
  drv_result_t driver_result_q[$];

  // expectation typed into the directed table, held with the request
  logic        cur_typed = 1'b0;
  drv_result_t cur_typed_want = '0;

  bit sender_idle = 1'b1;
  bit sink_idle = 1'b1;
  bit hold_request = 1'b0;
  int fail_count = 0;
  int stalled_cycles = 0;

  function automatic command_t make_cmd(input logic [3:0] kind, input logic [3:0] row,
                                        input logic [3:0] col, input logic [7:0] val,
                                        input logic on, input logic wrap);
    command_t c;
    c = '{kind, row, col, val, on, wrap};
    return c;
  endfunction

  function automatic drv_result_t status_res(input logic [1:0] st);
    drv_result_t r;
    r = '{4'h0, 8'h00, 1'b0, 1'b0, st, 1'b1};
    return r;
  endfunction

  function automatic drv_result_t write_res(input logic [3:0] addr, input logic [7:0] data,
                                            input logic [1:0] st);
    drv_result_t r;
    r = '{addr, data, 1'b1, 1'b0, st, 1'b1};
    return r;
  endfunction

  function automatic void add_result(input logic [3:0] addr, input logic [7:0] data,
                                     input logic wv, input logic pix, input logic [1:0] st);
    drv_result_t r;
    r = '{addr, data, wv, pix, st, 1'b0};
    fresh_results.push_back(r);
  endfunction

  function automatic void add_all_rows();
    for (int r = 0; r < Dim; r++) begin
      add_result(AddrDigit0 + 4'(r), model_rows[r], 1'b1, 1'b0, StatusOk);
    end
  endfunction

  // updates the frame model and leaves the command's results in fresh_results
  function automatic void predict_command(input command_t c);
    logic [7:0] v;
    logic       out_of_range;
    fresh_results.delete();
    if (c.kind > KindPowerDown) return;
    out_of_range = (c.row_index >= Dim) || (c.col_index >= Dim);
    if (!model_powered && c.kind != KindPowerUp) begin
      add_result(4'h0, 8'h00, 1'b0, 1'b0, StatusNotPowered);
    end else begin
      case (c.kind)
        KindSetPixel: begin
          if (out_of_range) begin
            add_result(4'h0, 8'h00, 1'b0, 1'b0, StatusRange);
          end else begin
            model_rows[c.row_index[2:0]][c.col_index[2:0]] = c.pixel_on;
            add_result(AddrDigit0 + c.row_index, model_rows[c.row_index[2:0]],
                       1'b1, 1'b0, StatusOk);
          end
        end
        KindGetPixel: begin
          if (out_of_range) begin
            add_result(4'h0, 8'h00, 1'b0, 1'b0, StatusRange);
          end else begin
            add_result(4'h0, 8'h00, 1'b0,
                       model_rows[c.row_index[2:0]][c.col_index[2:0]], StatusOk);
          end
        end
        KindSetRow: begin
          if (c.row_index >= Dim) begin
            add_result(4'h0, 8'h00, 1'b0, 1'b0, StatusRange);
          end else begin
            model_rows[c.row_index[2:0]] = c.value_byte;
            add_result(AddrDigit0 + c.row_index, c.value_byte, 1'b1, 1'b0, StatusOk);
          end
        end
        KindSetColumn: begin
          if (c.col_index >= Dim) begin
            add_result(4'h0, 8'h00, 1'b0, 1'b0, StatusRange);
          end else begin
            for (int r = 0; r < Dim; r++) begin
              model_rows[r][c.col_index[2:0]] = c.value_byte[r];
              add_result(AddrDigit0 + 4'(r), model_rows[r], 1'b1, 1'b0, StatusOk);
            end
          end
        end
        KindShiftLeft, KindShiftRight: begin
          for (int r = 0; r < Dim; r++) begin
            v = model_rows[r];
            if (c.kind == KindShiftLeft) begin
              model_rows[r] = {v[6:0], c.wrap_around & v[7]};
            end else begin
              model_rows[r] = {c.wrap_around & v[0], v[7:1]};
            end
          end
          add_all_rows();
        end
        KindClear: begin
          for (int r = 0; r < Dim; r++) model_rows[r] = 8'h00;
          add_all_rows();
        end
        KindRefresh: begin
          add_all_rows();
        end
        KindIntensity: begin
          if (c.value_byte > IntensityMax) begin
            add_result(AddrIntensity, IntensityMax, 1'b1, 1'b0, StatusClamped);
          end else begin
            add_result(AddrIntensity, c.value_byte, 1'b1, 1'b0, StatusOk);
          end
        end
        KindPowerUp: begin
          for (int r = 0; r < Dim; r++) model_rows[r] = 8'h00;
          add_result(AddrShutdown, ShutdownOn, 1'b1, 1'b0, StatusOk);
          add_result(AddrDispTest, 8'h00, 1'b1, 1'b0, StatusOk);
          add_result(AddrDecode, 8'h00, 1'b1, 1'b0, StatusOk);
          add_result(AddrScanLimit, 8'(Dim - 1), 1'b1, 1'b0, StatusOk);
          add_result(AddrIntensity, IntensityInit, 1'b1, 1'b0, StatusOk);
          add_all_rows();
          add_result(AddrShutdown, ShutdownOff, 1'b1, 1'b0, StatusOk);
          model_powered = 1'b1;
        end
        default: begin
          add_result(AddrShutdown, ShutdownOn, 1'b1, 1'b0, StatusOk);
          model_powered = 1'b0;
        end
      endcase
    end
    if (fresh_results.size() > 0) fresh_results[fresh_results.size() - 1].last = 1'b1;
  endfunction

  // sampled at the rising edge, inputs settle at the falling edge
  always @(posedge clk_i) begin : bus_monitor
    drv_result_t got;
    drv_result_t want;
    command_t    taken;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.reg_addr, res_if.reg_data, res_if.write_valid, res_if.pixel_value,
                res_if.status, res_if.last};
        if (driver_result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected result addr=%h data=%h wv=%b pix=%b st=%0d last=%b",
                     $realtime, got.reg_addr, got.reg_data, got.write_valid,
                     got.pixel_value, got.status, got.last);
          end
        end else begin
          want = driver_result_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected addr=%h data=%h wv=%b pix=%b st=%0d last=%b",
                       want.reg_addr, want.reg_data, want.write_valid, want.pixel_value,
                       want.status, want.last);
              $display("  actual   addr=%h data=%h wv=%b pix=%b st=%0d last=%b",
                       got.reg_addr, got.reg_data, got.write_valid, got.pixel_value,
                       got.status, got.last);
            end
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        taken = '{cmd_if.kind, cmd_if.row_index, cmd_if.col_index, cmd_if.value_byte,
                  cmd_if.pixel_on, cmd_if.wrap_around};
        predict_command(taken);
        if (cur_typed) begin
          driver_result_q.push_back(cur_typed_want);
        end else begin
          foreach (fresh_results[i]) driver_result_q.push_back(fresh_results[i]);
        end
      end
      if ((res_if.valid && res_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
        stalled_cycles <= 0;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    while (stalled_cycles < WatchdogLimit) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (SinkHoldCycles) @(negedge clk_i);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // starts and ends at a falling edge, returns once the request is taken
  task automatic issue_command(input command_t c, input logic typed, input drv_result_t want);
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (sender_idle && roll >= 55) begin
      gap = (roll < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.kind        <= c.kind;
    cmd_if.row_index   <= c.row_index;
    cmd_if.col_index   <= c.col_index;
    cmd_if.value_byte  <= c.value_byte;
    cmd_if.pixel_on    <= c.pixel_on;
    cmd_if.wrap_around <= c.wrap_around;
    cur_typed          <= typed;
    cur_typed_want     <= want;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (driver_result_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly well-formed traffic after a power up, some power cycling and noise
  task automatic send_phase(input int count);
    command_t c;
    int roll;
    int sent;
    sent = 0;
    issue_command(make_cmd(KindPowerUp, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0), 1'b0, '0);
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) c.kind = KindPowerDown;
      else if (roll < 9) c.kind = KindPowerUp;
      else if (roll < 12) c.kind = 4'($urandom_range(KindUnusedLow, KindUnusedTop));
      else c.kind = 4'($urandom_range(KindSetPixel, KindIntensity));
      c.row_index = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 7))
                                                 : 4'($urandom_range(8, 15));
      c.col_index = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 7))
                                                 : 4'($urandom_range(8, 15));
      c.value_byte = 8'($urandom_range(0, 255));
      if (c.kind == KindIntensity && $urandom_range(0, 1) == 1) begin
        c.value_byte = 8'($urandom_range(0, 20));
      end
      c.pixel_on    = 1'($urandom_range(0, 1));
      c.wrap_around = 1'($urandom_range(0, 1));
      issue_command(c, 1'b0, '0);
      if (c.kind <= KindPowerDown) sent++;
    end
  endtask

  initial begin : stimulus
    table_row_t directed_rows[$];
    for (int r = 0; r < Dim; r++) model_rows[r] = 8'h00;
    model_powered = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.kind        = 4'd0;
    cmd_if.row_index   = 4'd0;
    cmd_if.col_index   = 4'd0;
    cmd_if.value_byte  = 8'h00;
    cmd_if.pixel_on    = 1'b0;
    cmd_if.wrap_around = 1'b0;

    // before power up
    directed_rows.push_back('{make_cmd(KindSetPixel, 4'd0, 4'd0, 8'h00, 1'b1, 1'b0),
                              1'b1, status_res(StatusNotPowered)});
    directed_rows.push_back('{make_cmd(KindIntensity, 4'd0, 4'd0, 8'hFF, 1'b0, 1'b0),
                              1'b1, status_res(StatusNotPowered)});
    directed_rows.push_back('{make_cmd(KindUnusedLow, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0),
                              1'b0, '0});
    // start-up, twice
    directed_rows.push_back('{make_cmd(KindPowerUp, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindPowerUp, 4'd15, 4'd15, 8'hFF, 1'b1, 1'b1),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindUnusedTop, 4'd15, 4'd15, 8'hFF, 1'b1, 1'b1),
                              1'b0, '0});
    // pixels and range errors
    directed_rows.push_back('{make_cmd(KindSetPixel, 4'd7, 4'd7, 8'h00, 1'b1, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindSetPixel, 4'd0, 4'd0, 8'hFF, 1'b1, 1'b1),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindGetPixel, 4'd7, 4'd7, 8'h00, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindGetPixel, 4'd8, 4'd0, 8'h00, 1'b0, 1'b0),
                              1'b1, status_res(StatusRange)});
    directed_rows.push_back('{make_cmd(KindSetPixel, 4'd15, 4'd3, 8'h00, 1'b1, 1'b0),
                              1'b1, status_res(StatusRange)});
    directed_rows.push_back('{make_cmd(KindSetPixel, 4'd2, 4'd15, 8'h00, 1'b1, 1'b0),
                              1'b1, status_res(StatusRange)});
    // rows and columns
    directed_rows.push_back('{make_cmd(KindSetRow, 4'd3, 4'd0, 8'hFF, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindSetRow, 4'd8, 4'd0, 8'h55, 1'b0, 1'b0),
                              1'b1, status_res(StatusRange)});
    directed_rows.push_back('{make_cmd(KindSetColumn, 4'd0, 4'd7, 8'hA5, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindSetColumn, 4'd0, 4'd15, 8'hFF, 1'b0, 1'b0),
                              1'b1, status_res(StatusRange)});
    // shifts with and without wrap
    directed_rows.push_back('{make_cmd(KindShiftLeft, 4'd0, 4'd0, 8'h00, 1'b0, 1'b1),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindShiftRight, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindShiftRight, 4'd0, 4'd0, 8'h00, 1'b0, 1'b1),
                              1'b0, '0});
    // intensity extremes, refresh, clear, then power down and a refresh while off
    directed_rows.push_back('{make_cmd(KindIntensity, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0),
                              1'b1, write_res(AddrIntensity, 8'h00, StatusOk)});
    directed_rows.push_back('{make_cmd(KindIntensity, 4'd0, 4'd0, 8'hFF, 1'b0, 1'b0),
                              1'b1, write_res(AddrIntensity, IntensityMax, StatusClamped)});
    directed_rows.push_back('{make_cmd(KindRefresh, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindClear, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0),
                              1'b0, '0});
    directed_rows.push_back('{make_cmd(KindPowerDown, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0),
                              1'b1, write_res(AddrShutdown, ShutdownOn, StatusOk)});
    directed_rows.push_back('{make_cmd(KindRefresh, 4'd0, 4'd0, 8'h00, 1'b0, 1'b0),
                              1'b1, status_res(StatusNotPowered)});

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      issue_command(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    sender_idle = 1'b1;
    sink_idle = 1'b1;
    send_phase(50);

    sender_idle = 1'b0;
    sink_idle = 1'b0;
    send_phase(40);

    // long result hold-off while requests keep coming, then a full drain
    sink_idle = 1'b1;
    hold_request = 1'b1;
    send_phase(35);
    drain_results();

    sender_idle = 1'b1;
    send_phase(50);
    drain_results();
    repeat (EndPause) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
